>>> rtl/mmh_pkg.sv
// Shared types, constants and helper functions for the min-max heap insert block.
// No dependencies; used by mmh_ctrl, mmh_dp and min_max_heap_insert.
package mmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 16;
    localparam int SLOT_W   = 11;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = 4;

    // One heap word: arrival number and key
    typedef struct packed {
        logic [SLOT_W-1:0] tag;
        logic [KEY_W-1:0]  key;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAR_RD,
        S_PAR_CMP,
        S_GP_CHK,
        S_GP_CMP,
        S_REP0,
        S_REP1,
        S_REP2,
        S_REP3
    } state_t;

    typedef enum logic [2:0] {
        RD_PARENT,
        RD_GRAND,
        RD_ROOT,
        RD_LAST,
        RD_BOTTOM
    } rd_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    start;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    par_step;
        logic    gp_move_step;
        logic    place_new;
        logic    cap_root;
        logic    cap_last;
        logic    load_out;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic cur_ge4;
        logic gp_move;
    } status_t;

    // Position of the highest set bit (level of a 1-based slot)
    function automatic logic [POS_W-1:0] msb_pos(input logic [SLOT_W-1:0] s);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < SLOT_W; i++)
        begin
            if (s[i])
            begin
                pos = POS_W'(i);
            end
        end
        return pos;
    endfunction

    // Largest power of two not above s (first slot of the bottom level)
    function automatic logic [SLOT_W-1:0] floor_pow2(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] p;
        p = '0;
        for (int i = 0; i < SLOT_W; i++)
        begin
            if (s[i])
            begin
                p = SLOT_W'(1) << i;
            end
        end
        return p;
    endfunction

endpackage

>>> rtl/mmh_ctrl.sv
// Sequencer for the min-max heap insert: parent step, grandparent walk, report reads.
// Depends on mmh_pkg; drives mmh_dp through cmd_t and reads status_t.
module mmh_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  mmh_pkg::status_t status,
    output mmh_pkg::cmd_t    cmd
);

    mmh_pkg::state_t state_reg;
    mmh_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmh_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output slot can take a new word if empty or being taken now
    assign out_free = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = mmh_pkg::RD_ROOT;
        case (state_reg)
            mmh_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (status.full)
                        state_next = mmh_pkg::S_REP0;
                    else if (status.empty)
                        state_next = mmh_pkg::S_GP_CHK;
                    else
                        state_next = mmh_pkg::S_PAR_RD;
                end
            end
            mmh_pkg::S_PAR_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = mmh_pkg::RD_PARENT;
                state_next = mmh_pkg::S_PAR_CMP;
            end
            mmh_pkg::S_PAR_CMP:
            begin
                cmd.par_step = 1'b1;
                state_next   = mmh_pkg::S_GP_CHK;
            end
            mmh_pkg::S_GP_CHK:
            begin
                if (status.cur_ge4)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = mmh_pkg::RD_GRAND;
                    state_next = mmh_pkg::S_GP_CMP;
                end
                else
                begin
                    cmd.place_new = 1'b1;
                    state_next    = mmh_pkg::S_REP0;
                end
            end
            mmh_pkg::S_GP_CMP:
            begin
                if (status.gp_move)
                begin
                    cmd.gp_move_step = 1'b1;
                    state_next       = mmh_pkg::S_GP_CHK;
                end
                else
                begin
                    cmd.place_new = 1'b1;
                    state_next    = mmh_pkg::S_REP0;
                end
            end
            mmh_pkg::S_REP0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = mmh_pkg::RD_ROOT;
                state_next = mmh_pkg::S_REP1;
            end
            mmh_pkg::S_REP1:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = mmh_pkg::RD_LAST;
                cmd.cap_root = 1'b1;
                state_next   = mmh_pkg::S_REP2;
            end
            mmh_pkg::S_REP2:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = mmh_pkg::RD_BOTTOM;
                cmd.cap_last = 1'b1;
                state_next   = mmh_pkg::S_REP3;
            end
            mmh_pkg::S_REP3:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = mmh_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mmh_pkg::S_IDLE;
            end
        endcase
    end

    // Output word valid: set on load, cleared when taken
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_stall  = (state_reg != mmh_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/mmh_dp.sv
// Datapath for the min-max heap insert: heap memory, hole pointer, compares, report regs.
// Depends on mmh_pkg; commanded by mmh_ctrl.
module mmh_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mmh_pkg::cmd_t                cmd,
    output mmh_pkg::status_t             status,
    input  logic [mmh_pkg::KEY_W-1:0]    key_value,
    output logic                         dropped,
    output logic [mmh_pkg::SLOT_W-1:0]   entry_count,
    output logic [mmh_pkg::SLOT_W-1:0]   root_tag,
    output logic [mmh_pkg::KEY_W-1:0]    root_key,
    output logic [mmh_pkg::SLOT_W-1:0]   last_tag,
    output logic [mmh_pkg::KEY_W-1:0]    last_key,
    output logic [mmh_pkg::SLOT_W-1:0]   bottom_first_tag,
    output logic [mmh_pkg::KEY_W-1:0]    bottom_first_key
);

    // Heap storage, slot s lives at address s-1
    mmh_pkg::entry_t heap_mem [mmh_pkg::CAPACITY];

    logic [mmh_pkg::SLOT_W-1:0] occ_reg;
    logic [mmh_pkg::SLOT_W-1:0] cur_reg;
    logic [mmh_pkg::SLOT_W-1:0] cur_next;
    logic [mmh_pkg::KEY_W-1:0]  new_key_reg;
    logic [mmh_pkg::SLOT_W-1:0] new_tag_reg;
    logic                       dir_min_reg;
    logic                       dir_min_next;
    logic                       dropped_reg;
    mmh_pkg::entry_t            rd_q_reg;
    mmh_pkg::entry_t            root_hold_reg;
    mmh_pkg::entry_t            last_hold_reg;

    logic                       out_dropped_reg;
    logic [mmh_pkg::SLOT_W-1:0] out_count_reg;
    mmh_pkg::entry_t            out_root_reg;
    mmh_pkg::entry_t            out_last_reg;
    mmh_pkg::entry_t            out_bottom_reg;

    logic                       full;
    logic [mmh_pkg::POS_W-1:0]  cur_level;
    logic                       cur_min_level;
    logic                       par_move;
    logic                       gp_move;
    logic [mmh_pkg::SLOT_W-1:0] rd_slot;
    logic [mmh_pkg::ADDR_W-1:0] rd_addr;
    logic                       wr_en;
    logic [mmh_pkg::ADDR_W-1:0] wr_addr;
    mmh_pkg::entry_t            wr_data;
    mmh_pkg::entry_t            new_entry;

    assign full          = (occ_reg == mmh_pkg::SLOT_W'(mmh_pkg::CAPACITY));
    assign cur_level     = mmh_pkg::msb_pos(cur_reg);
    assign cur_min_level = !cur_level[0];
    assign new_entry     = '{tag: new_tag_reg, key: new_key_reg};

    // Compares of the moving key against the word just read
    assign par_move = cur_min_level ? (new_key_reg > rd_q_reg.key)
                                    : (new_key_reg < rd_q_reg.key);
    assign gp_move  = dir_min_reg ? (new_key_reg < rd_q_reg.key)
                                  : (new_key_reg > rd_q_reg.key);

    assign status.full    = full;
    assign status.empty   = (occ_reg == '0);
    assign status.cur_ge4 = (cur_reg >= mmh_pkg::SLOT_W'(4));
    assign status.gp_move = gp_move;

    // Read slot select
    always_comb
    begin
        case (cmd.rd_sel)
            mmh_pkg::RD_PARENT: rd_slot = cur_reg >> 1;
            mmh_pkg::RD_GRAND:  rd_slot = cur_reg >> 2;
            mmh_pkg::RD_ROOT:   rd_slot = mmh_pkg::SLOT_W'(1);
            mmh_pkg::RD_LAST:   rd_slot = occ_reg;
            mmh_pkg::RD_BOTTOM: rd_slot = mmh_pkg::floor_pow2(occ_reg);
            default:            rd_slot = mmh_pkg::SLOT_W'(1);
        endcase
    end
    assign rd_addr = mmh_pkg::ADDR_W'(rd_slot - mmh_pkg::SLOT_W'(1));

    // Write: shift an ancestor down into the hole, or drop the new word in
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = rd_q_reg;
        if (cmd.par_step && par_move)
            wr_en = 1'b1;
        if (cmd.gp_move_step)
            wr_en = 1'b1;
        if (cmd.place_new)
        begin
            wr_en   = 1'b1;
            wr_data = new_entry;
        end
    end
    assign wr_addr = mmh_pkg::ADDR_W'(cur_reg - mmh_pkg::SLOT_W'(1));

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            heap_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_q_reg <= heap_mem[rd_addr];
    end

    // Hole pointer and sift direction
    always_comb
    begin
        cur_next     = cur_reg;
        dir_min_next = dir_min_reg;
        if (cmd.start)
            cur_next = occ_reg + mmh_pkg::SLOT_W'(1);
        if (cmd.par_step)
        begin
            if (par_move)
            begin
                cur_next     = cur_reg >> 1;
                dir_min_next = !cur_min_level;
            end
            else
            begin
                dir_min_next = cur_min_level;
            end
        end
        if (cmd.gp_move_step)
            cur_next = cur_reg >> 2;
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else if (cmd.start && !full)
            occ_reg <= occ_reg + mmh_pkg::SLOT_W'(1);
    end

    // Working and report registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        dir_min_reg <= dir_min_next;
        if (cmd.start)
        begin
            new_key_reg <= key_value;
            new_tag_reg <= occ_reg + mmh_pkg::SLOT_W'(1);
            dropped_reg <= full;
        end
        if (cmd.cap_root)
            root_hold_reg <= rd_q_reg;
        if (cmd.cap_last)
            last_hold_reg <= rd_q_reg;
        if (cmd.load_out)
        begin
            out_dropped_reg <= dropped_reg;
            out_count_reg   <= occ_reg;
            out_root_reg    <= root_hold_reg;
            out_last_reg    <= last_hold_reg;
            out_bottom_reg  <= rd_q_reg;
        end
    end

    assign dropped          = out_dropped_reg;
    assign entry_count      = out_count_reg;
    assign root_tag         = out_root_reg.tag;
    assign root_key         = out_root_reg.key;
    assign last_tag         = out_last_reg.tag;
    assign last_key         = out_last_reg.key;
    assign bottom_first_tag = out_bottom_reg.tag;
    assign bottom_first_key = out_bottom_reg.key;

endmodule

>>> rtl/min_max_heap_insert.sv
// Top level of the min-max heap insert block: controller plus datapath.
// Depends on mmh_pkg, mmh_ctrl and mmh_dp.
//
// Each accepted word inserts one 16-bit key into a min-max heap of 1024 slots,
// tagged with its arrival number, and yields one result word: drop flag, entry
// count, and tag/key of the root (minimum), the last slot and the first slot of
// the bottom level. Keys are held in a single-port 1024-word memory with a
// registered read, so each level climbed takes a read step and then a compare
// and write step; a climb makes at most 5 grandparent hops here. The first
// insert into an empty heap skips the parent and grandparent reads, and an
// insert into a full heap is dropped and goes straight to the report reads.
// A new word is taken only when the previous insert has finished; the result
// register lets the next insert run while the previous result waits to be
// taken.
module min_max_heap_insert (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mmh_pkg::KEY_W-1:0]    key_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         dropped,
    output logic [mmh_pkg::SLOT_W-1:0]   entry_count,
    output logic [mmh_pkg::SLOT_W-1:0]   root_tag,
    output logic [mmh_pkg::KEY_W-1:0]    root_key,
    output logic [mmh_pkg::SLOT_W-1:0]   last_tag,
    output logic [mmh_pkg::KEY_W-1:0]    last_key,
    output logic [mmh_pkg::SLOT_W-1:0]   bottom_first_tag,
    output logic [mmh_pkg::KEY_W-1:0]    bottom_first_key
);

    mmh_pkg::cmd_t    cmd;
    mmh_pkg::status_t status;

    mmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mmh_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .key_value        (key_value),
        .dropped          (dropped),
        .entry_count      (entry_count),
        .root_tag         (root_tag),
        .root_key         (root_key),
        .last_tag         (last_tag),
        .last_key         (last_key),
        .bottom_first_tag (bottom_first_tag),
        .bottom_first_key (bottom_first_key)
    );

    // An accepted word starts an insert, so no second word is taken right after
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an insert is in progress");

    // Count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= mmh_pkg::SLOT_W'(mmh_pkg::CAPACITY)))
        else $error("entry count above capacity");

    // A drop is reported only with a full heap
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped) |->
            (entry_count == mmh_pkg::SLOT_W'(mmh_pkg::CAPACITY)))
        else $error("drop reported with heap not full");

    // Root holds the minimum
    a_root_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((root_key <= last_key) && (root_key <= bottom_first_key)))
        else $error("root key is not the heap minimum");

endmodule

>>> tb/sv/tb_min_max_heap_insert.sv
`timescale 1ns / 100ps
// Self-checking testbench for min_max_heap_insert: random idle/stall on both sides,
// with an in-bench min-max heap predictor checking every result word. Depends on mmh_pkg.
module tb_min_max_heap_insert;

    localparam int TOTAL_WORDS = 1050;
    localparam int MAX_WAIT    = 11;
    localparam int SHOW_LIMIT  = 40;

    typedef struct packed {
        logic                       dropped;
        logic [mmh_pkg::SLOT_W-1:0] entry_count;
        mmh_pkg::entry_t            root;
        mmh_pkg::entry_t            last;
        mmh_pkg::entry_t            bottom;
    } heap_report_t;

    typedef struct {
        logic [mmh_pkg::KEY_W-1:0] key;
        int unsigned               gap;
        bit                        drain;
    } key_word_t;

    typedef enum int {
        SHAPE_SPREAD,
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_CLUSTER,
        SHAPE_EXTREME
    } key_shape_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [mmh_pkg::KEY_W-1:0]   key_value = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        dropped;
    logic [mmh_pkg::SLOT_W-1:0]  entry_count;
    logic [mmh_pkg::SLOT_W-1:0]  root_tag;
    logic [mmh_pkg::KEY_W-1:0]   root_key;
    logic [mmh_pkg::SLOT_W-1:0]  last_tag;
    logic [mmh_pkg::KEY_W-1:0]   last_key;
    logic [mmh_pkg::SLOT_W-1:0]  bottom_first_tag;
    logic [mmh_pkg::KEY_W-1:0]   bottom_first_key;

    key_word_t     key_backlog[$];
    heap_report_t  expected_reports[$];
    int unsigned   mismatch_count = 0;
    int unsigned   reports_seen = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   stall_left = 0;
    bit            sender_calm = 1'b0;

    // shadow copy of the heap, slots numbered from 1
    mmh_pkg::entry_t shadow_heap [1:mmh_pkg::CAPACITY];
    int unsigned     heap_fill = 0;

    min_max_heap_insert i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .key_value        (key_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .dropped          (dropped),
        .entry_count      (entry_count),
        .root_tag         (root_tag),
        .root_key         (root_key),
        .last_tag         (last_tag),
        .last_key         (last_key),
        .bottom_first_tag (bottom_first_tag),
        .bottom_first_key (bottom_first_key)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic log_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
        if (mismatch_count < SHOW_LIMIT)
        begin
            $display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
                     $realtime, what, reports_seen, got, want);
        end
        mismatch_count++;
    endtask

    // Level 0 (root) is a min level; levels alternate below it
    function automatic bit on_min_level(input int unsigned slot);
        int unsigned depth;
        depth = 0;
        while (slot > 1)
        begin
            slot = slot >> 1;
            depth++;
        end
        return (depth % 2) == 0;
    endfunction

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        mmh_pkg::entry_t held;
        held           = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = held;
    endfunction

    // Climb through grandparents while strictly out of order
    function automatic void climb_grand(input int unsigned slot, input bit toward_min);
        int unsigned g;
        bit          move;
        while (slot >= 4)
        begin
            g    = slot >> 2;
            move = toward_min ? (shadow_heap[slot].key < shadow_heap[g].key)
                              : (shadow_heap[slot].key > shadow_heap[g].key);
            if (!move)
            begin
                break;
            end
            swap_slots(slot, g);
            slot = g;
        end
    endfunction

    // Insert one key into the shadow heap and build the result word it yields
    function automatic heap_report_t heap_insert_predict(
        input logic [mmh_pkg::KEY_W-1:0] key);
        heap_report_t rep;
        int unsigned  slot;
        int unsigned  parent;
        int unsigned  bottom;
        rep = '0;
        if (heap_fill >= mmh_pkg::CAPACITY)
        begin
            rep.dropped = 1'b1;
        end
        else
        begin
            heap_fill++;
            slot = heap_fill;
            shadow_heap[slot].key = key;
            shadow_heap[slot].tag = mmh_pkg::SLOT_W'(slot);
            if (slot > 1)
            begin
                parent = slot >> 1;
                if (on_min_level(slot))
                begin
                    if (key > shadow_heap[parent].key)
                    begin
                        swap_slots(slot, parent);
                        climb_grand(parent, 1'b0);
                    end
                    else
                    begin
                        climb_grand(slot, 1'b1);
                    end
                end
                else
                begin
                    if (key < shadow_heap[parent].key)
                    begin
                        swap_slots(slot, parent);
                        climb_grand(parent, 1'b1);
                    end
                    else
                    begin
                        climb_grand(slot, 1'b0);
                    end
                end
            end
        end
        rep.entry_count = mmh_pkg::SLOT_W'(heap_fill);
        if (heap_fill != 0)
        begin
            bottom = 1;
            while ((bottom << 1) <= heap_fill)
            begin
                bottom = bottom << 1;
            end
            rep.root   = shadow_heap[1];
            rep.last   = shadow_heap[heap_fill];
            rep.bottom = shadow_heap[bottom];
        end
        return rep;
    endfunction

    task automatic queue_key(input logic [mmh_pkg::KEY_W-1:0] key, input bit drain);
        key_word_t w;
        w.key       = key;
        w.gap       = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
        w.drain     = drain;
        key_backlog = {key_backlog, w};
    endtask

    // Sender: predict on acceptance, then present the next word after its gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            key_value   <= '0;
            idle_cycles = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_reports = {expected_reports, heap_insert_predict(key_value)};
            end
            if (!in_valid || !in_stall)
            begin
                if (key_backlog.size() != 0 && idle_cycles >= key_backlog[0].gap &&
                    !(key_backlog[0].drain && expected_reports.size() != 0))
                begin
                    in_valid    <= 1'b1;
                    key_value   <= key_backlog[0].key;
                    void'(key_backlog.pop_front());
                    idle_cycles = 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (key_backlog.size() != 0)
                    begin
                        idle_cycles++;
                    end
                end
            end
        end
    end

    // Receiver: check each accepted result word, then draw the next stall
    always @(posedge clk or negedge rst_n)
    begin
        heap_report_t got;
        heap_report_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.dropped     = dropped;
                got.entry_count = entry_count;
                got.root        = '{tag: root_tag, key: root_key};
                got.last        = '{tag: last_tag, key: last_key};
                got.bottom      = '{tag: bottom_first_tag, key: bottom_first_key};
                if (expected_reports.size() == 0)
                begin
                    log_mismatch("unexpected word", 1, 0);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.dropped != want.dropped)
                        log_mismatch("dropped", got.dropped, want.dropped);
                    if (got.entry_count != want.entry_count)
                        log_mismatch("entry_count", got.entry_count, want.entry_count);
                    if (got.root.tag != want.root.tag)
                        log_mismatch("root_tag", got.root.tag, want.root.tag);
                    if (got.root.key != want.root.key)
                        log_mismatch("root_key", got.root.key, want.root.key);
                    if (got.last.tag != want.last.tag)
                        log_mismatch("last_tag", got.last.tag, want.last.tag);
                    if (got.last.key != want.last.key)
                        log_mismatch("last_key", got.last.key, want.last.key);
                    if (got.bottom.tag != want.bottom.tag)
                        log_mismatch("bottom_first_tag", got.bottom.tag, want.bottom.tag);
                    if (got.bottom.key != want.bottom.key)
                        log_mismatch("bottom_first_key", got.bottom.key, want.bottom.key);
                end
                reports_seen++;
                // every fifth stretch of results runs with no stall
                stall_left = (((reports_seen / 90) % 5) == 2) ? 0
                                                               : $urandom_range(0, MAX_WAIT);
            end
            else if (out_valid && stall_left != 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        logic [mmh_pkg::KEY_W-1:0] dir_keys[$];
        key_shape_t                shape;
        int unsigned               seg;
        int unsigned               len;
        int unsigned               pace;
        int unsigned               base;
        int unsigned               queued;
        logic [mmh_pkg::KEY_W-1:0] k;

        // directed: extremes, equal keys, rising and falling runs
        dir_keys = {16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h7FFF,
                    16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA, 16'h9000, 16'h8000,
                    16'h7000, 16'h6000, 16'h0100, 16'h0200, 16'h0300, 16'h0400,
                    16'h4000, 16'h4000, 16'h4000, 16'hC000};
        sender_calm = 1'b1;
        foreach (dir_keys[i])
        begin
            if (i == 6)
            begin
                sender_calm = 1'b0;
            end
            queue_key(dir_keys[i], 1'b0);
        end
        queued = dir_keys.size();

        // random runs of shaped keys; the heap fills and later words drop
        seg = 0;
        while (queued < TOTAL_WORDS)
        begin
            shape       = key_shape_t'($urandom_range(0, 4));
            len         = $urandom_range(8, 40);
            pace        = $urandom_range(1, 300);
            base        = $urandom_range(0, 65535);
            sender_calm = (seg % 6) == 3;
            for (int i = 0; i < len && queued < TOTAL_WORDS; i++)
            begin
                case (shape)
                    SHAPE_RISING:  k = mmh_pkg::KEY_W'(base + i * pace);
                    SHAPE_FALLING: k = mmh_pkg::KEY_W'(base - i * pace);
                    SHAPE_CLUSTER: k = mmh_pkg::KEY_W'(base + $urandom_range(0, 3));
                    SHAPE_EXTREME: k = $urandom_range(0, 1) ? '1 : '0;
                    default:       k = mmh_pkg::KEY_W'($urandom_range(0, 65535));
                endcase
                // now and then hold off until every pending result is back
                queue_key(k, i == 0 && (seg % 7) == 0);
                queued++;
            end
            seg++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (key_backlog.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
